[src/deq_pkg.sv]
// Shared widths, command codes and status codes of the double-ended queue.
`default_nettype none

package deq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int WORD_W    = 32;
	localparam int KIND_W    = 3;
	localparam int POS_W     = 7;
	localparam int STATUS_W  = 3;

	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;
	localparam logic [KIND_W-1:0] KIND_REVERSE    = 3'd5;
	localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd6;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_POS_HIGH = 3'd2;
	localparam logic [STATUS_W-1:0] ST_POS_LOW  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	localparam logic [WORD_W-1:0] ERR_DATA = {WORD_W{1'b1}};

endpackage

`default_nettype wire

[src/deq_ram.sv]
// Slot storage of the queue: one write port, one read port with registered read data.
`default_nettype none

module deq_ram
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [WORD_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[src/double_ended_queue.sv]
// Top level of the double-ended queue: command decode, ring pointers and result stage.
//
// A request is taken at every clock edge with start high; busy is never raised, so one
// command per cycle is sustained. Its result appears on the result ports in the next
// cycle, marked by done for that one cycle, and cannot be held off by the receiver. The
// result stage is registered to match the registered read port of the slot memory: pops fetch
// the new end value and reads fetch the addressed slot through it, while the values at
// both physical ends of the ring are kept in registers so that pushes need no read.
// Slots are not cleared at reset; only slots that hold stored values are ever shown.
`default_nettype none

module double_ended_queue
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [KIND_W-1:0]    kind,
	input  wire logic signed [31:0]   value,
	input  wire logic [POS_W-1:0]     position,
	output logic                      done,
	output logic signed [31:0]        data,
	output logic [STATUS_W-1:0]       status,
	output logic [CW-1:0]             occupancy,
	output logic signed [31:0]        front_value,
	output logic signed [31:0]        back_value
);

	localparam int AW   = $clog2(DEPTH);
	localparam int OW   = AW + 1;
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic                rev_q;
	logic                done_q;
	logic                pf_mem_q;
	logic                pl_mem_q;
	logic                dsel_s1;
	logic [WORD_W-1:0]   pfirst_q;
	logic [WORD_W-1:0]   plast_q;
	logic [WORD_W-1:0]   data_s1;
	logic [STATUS_W-1:0] status_s1;

	logic [WORD_W-1:0]   rd_data;
	logic [WORD_W-1:0]   cur_pfirst;
	logic [WORD_W-1:0]   cur_plast;

	logic                take;
	logic [AW-1:0]       nhead;
	logic [CW-1:0]       ncount;
	logic                nrev;
	logic [WORD_W-1:0]   npf;
	logic [WORD_W-1:0]   npl;
	logic                npf_mem;
	logic                npl_mem;
	logic                ndsel;
	logic [WORD_W-1:0]   ndata;
	logic [STATUS_W-1:0] nstatus;
	logic                we;
	logic [AW-1:0]       waddr;
	logic                re;
	logic [AW-1:0]       raddr;

	logic [OW-1:0]       head_x;
	logic [OW-1:0]       count_x;
	logic [AW-1:0]       head_m1;
	logic [OW-1:0]       rd_off;
	logic                is_empty;
	logic                is_full;
	logic                to_end;
	logic                from_start;

	function automatic logic [AW-1:0] wrap(input logic [OW-1:0] a);
		logic [OW-1:0] t;
		if (a >= OW'(DEPTH)) begin
			t = a - OW'(DEPTH);
		end else begin
			t = a;
		end
		return t[AW-1:0];
	endfunction

	deq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (value),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_data)
	);

	assign busy = 1'b0;
	assign take = start && !busy;

	assign cur_pfirst = pf_mem_q ? rd_data : pfirst_q;
	assign cur_plast  = pl_mem_q ? rd_data : plast_q;

	assign head_x     = OW'(head_q);
	assign count_x    = OW'(count_q);
	assign head_m1    = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign is_empty   = (count_q == '0);
	assign is_full    = (count_q == CW'(DEPTH));
	assign to_end     = (kind == KIND_PUSH_BACK) != rev_q;
	assign from_start = (kind == KIND_POP_FRONT) != rev_q;
	assign rd_off     = rev_q ? count_x - OW'(position) : OW'(position) - OW'(1);

	always_comb begin
		nhead   = head_q;
		ncount  = count_q;
		nrev    = rev_q;
		npf     = cur_pfirst;
		npl     = cur_plast;
		npf_mem = 1'b0;
		npl_mem = 1'b0;
		ndsel   = 1'b0;
		ndata   = '0;
		nstatus = ST_OK;
		we      = 1'b0;
		waddr   = '0;
		re      = 1'b0;
		raddr   = '0;
		unique case (kind) inside
			KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
				if (is_full) begin
					nstatus = ST_FULL;
				end else begin
					we     = take;
					ncount = count_q + CW'(1);
					if (to_end) begin
						waddr = wrap(head_x + count_x);
						npl   = value;
						if (is_empty) begin
							npf = value;
						end
					end else begin
						waddr = head_m1;
						nhead = head_m1;
						npf   = value;
						if (is_empty) begin
							npl = value;
						end
					end
				end
			end
			KIND_POP_FRONT, KIND_POP_BACK: begin
				if (is_empty) begin
					nstatus = ST_EMPTY;
				end else begin
					ncount = count_q - CW'(1);
					re     = take;
					if (from_start) begin
						ndata   = cur_pfirst;
						raddr   = wrap(head_x + OW'(1));
						nhead   = wrap(head_x + OW'(1));
						npf_mem = 1'b1;
					end else begin
						ndata   = cur_plast;
						raddr   = wrap(head_x + count_x - OW'(2));
						npl_mem = 1'b1;
					end
				end
			end
			KIND_READ: begin
				if (CMPW'(position) > CMPW'(count_q)) begin
					nstatus = ST_POS_HIGH;
				end else if (position == '0) begin
					nstatus = ST_POS_LOW;
				end else begin
					re    = take;
					raddr = wrap(head_x + rd_off);
					ndsel = 1'b1;
				end
			end
			KIND_REVERSE: begin
				if (!is_empty) begin
					nrev = ~rev_q;
				end
			end
			default: begin
			end
		endcase
		if (nstatus != ST_OK) begin
			ndata = ERR_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			rev_q    <= 1'b0;
			done_q   <= 1'b0;
			pf_mem_q <= 1'b0;
			pl_mem_q <= 1'b0;
			dsel_s1  <= 1'b0;
		end else begin
			done_q <= take;
			if (take) begin
				head_q   <= nhead;
				count_q  <= ncount;
				rev_q    <= nrev;
				pf_mem_q <= npf_mem;
				pl_mem_q <= npl_mem;
				dsel_s1  <= ndsel;
			end else begin
				pf_mem_q <= 1'b0;
				pl_mem_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pfirst_q  <= npf;
			plast_q   <= npl;
			data_s1   <= ndata;
			status_s1 <= nstatus;
		end else begin
			pfirst_q <= cur_pfirst;
			plast_q  <= cur_plast;
		end
	end

	assign done        = done_q;
	assign data        = dsel_s1 ? rd_data : data_s1;
	assign status      = status_s1;
	assign occupancy   = count_q;
	assign front_value = (count_q == '0) ? '0 : (rev_q ? cur_plast : cur_pfirst);
	assign back_value  = (count_q == '0) ? '0 : (rev_q ? cur_pfirst : cur_plast);

`ifndef SYNTHESIS
	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("result strobe missing after request");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result strobe without request");

	a_occupancy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (occupancy <= CW'(DEPTH)))
		else $error("occupancy above depth");

	a_error_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (data == ERR_DATA))
		else $error("error result without error data");

	a_empty_ends_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && occupancy == '0) |-> (front_value == '0 && back_value == '0))
		else $error("empty queue shows nonzero end values");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for the double-ended queue: command driver, result monitor, predictor.
`timescale 1ns / 1ps

module tb;
	import deq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int LIMIT = 200000;
	localparam int CALM_LO = 700;
	localparam int CALM_HI = 1000;
	localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;

	localparam int MODE_FILL = 0;
	localparam int MODE_EMPTY = 1;
	localparam int MODE_MIXED = 2;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [31:0]       value;
		logic [POS_W-1:0]  position;
		bit                hold_off;
	} deq_request_t;

	typedef struct packed {
		logic [31:0]         data;
		logic [STATUS_W-1:0] status;
		logic [6:0]          occupancy;
		logic [31:0]         front_value;
		logic [31:0]         back_value;
	} deq_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [KIND_W-1:0]    kind = '0;
	logic signed [31:0]   value = '0;
	logic [POS_W-1:0]     position = '0;
	logic                 done;
	logic signed [31:0]   data;
	logic [STATUS_W-1:0]  status;
	logic [6:0]           occupancy;
	logic signed [31:0]   front_value;
	logic signed [31:0]   back_value;

	deq_request_t requests[$];
	deq_result_t  expected[$];

	logic [31:0] ring [DEPTH];
	int          ring_head = 0;
	int          ring_count = 0;
	bit          ring_flipped = 1'b0;

	int          issued = 0;
	int          results_seen = 0;
	int          errors = 0;
	int          planned_count = 0;
	int unsigned cycle_count = 0;

	double_ended_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.value(value),
		.position(position),
		.done(done),
		.data(data),
		.status(status),
		.occupancy(occupancy),
		.front_value(front_value),
		.back_value(back_value)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic int slot_of(int idx);
		if (ring_flipped)
			return (ring_head + ring_count - 1 - idx) % DEPTH;
		return (ring_head + idx) % DEPTH;
	endfunction

	function automatic deq_result_t apply_command(logic [KIND_W-1:0] k, logic [31:0] v,
			logic [POS_W-1:0] p);
		deq_result_t r;
		r = '0;
		case (k)
			KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
				if (ring_count >= DEPTH) begin
					r.status = ST_FULL;
				end else if ((k == KIND_PUSH_BACK) != ring_flipped) begin
					ring[(ring_head + ring_count) % DEPTH] = v;
					ring_count++;
				end else begin
					ring_head = (ring_head + DEPTH - 1) % DEPTH;
					ring[ring_head] = v;
					ring_count++;
				end
			end
			KIND_POP_FRONT, KIND_POP_BACK: begin
				if (ring_count == 0) begin
					r.status = ST_EMPTY;
				end else if ((k == KIND_POP_FRONT) != ring_flipped) begin
					r.data = ring[ring_head];
					ring_head = (ring_head + 1) % DEPTH;
					ring_count--;
				end else begin
					r.data = ring[(ring_head + ring_count - 1) % DEPTH];
					ring_count--;
				end
			end
			KIND_READ: begin
				if (int'(p) > ring_count)
					r.status = ST_POS_HIGH;
				else if (p == 0)
					r.status = ST_POS_LOW;
				else
					r.data = ring[slot_of(int'(p) - 1)];
			end
			KIND_REVERSE: begin
				if (ring_count != 0)
					ring_flipped = !ring_flipped;
			end
			default: begin
			end
		endcase
		if (r.status != ST_OK)
			r.data = ERR_DATA;
		r.occupancy = ring_count[6:0];
		if (ring_count != 0) begin
			r.front_value = ring[slot_of(0)];
			r.back_value = ring[slot_of(ring_count - 1)];
		end
		return r;
	endfunction

	task automatic add_request(logic [KIND_W-1:0] k, logic [31:0] v, logic [POS_W-1:0] p,
			bit hold);
		deq_request_t rq;
		rq.kind = k;
		rq.value = v;
		rq.position = p;
		rq.hold_off = hold;
		requests = {requests, rq};
		if ((k == KIND_PUSH_BACK || k == KIND_PUSH_FRONT) && planned_count < DEPTH)
			planned_count++;
		if ((k == KIND_POP_FRONT || k == KIND_POP_BACK) && planned_count > 0)
			planned_count--;
	endtask

	task automatic add_random(int mode, bit hold);
		int roll;
		int pick;
		int push_pct;
		int pop_pct;
		logic [KIND_W-1:0] k;
		logic [POS_W-1:0] p;
		roll = $urandom_range(0, 99);
		pick = $urandom_range(0, 9);
		push_pct = (mode == MODE_FILL) ? 85 : (mode == MODE_EMPTY) ? 10 : 35;
		pop_pct = (mode == MODE_FILL) ? 5 : (mode == MODE_EMPTY) ? 80 : 35;
		p = POS_W'($urandom_range(0, 127));
		if (roll < push_pct) begin
			k = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
		end else if (roll < push_pct + pop_pct) begin
			k = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
		end else begin
			roll = $urandom_range(0, 9);
			k = (roll < 6) ? KIND_READ : (roll < 8) ? KIND_REVERSE :
				(roll < 9) ? KIND_QUERY : KIND_SPARE;
			if (pick < 6 && planned_count > 0)
				p = POS_W'($urandom_range(1, planned_count));
			else if (pick == 6)
				p = '0;
			else if (pick == 7)
				p = POS_W'($urandom_range(planned_count + 1, 127));
		end
		add_request(k, $urandom, p, hold);
	endtask

	always @(posedge clk) begin
		bit idle;
		if (arst_n) begin
			if (start && !busy) begin
				expected = {expected, apply_command(kind, value, position)};
				issued++;
			end
			if (!(start && busy)) begin
				idle = ($urandom_range(0, 99) < 37) && !(issued >= CALM_LO && issued < CALM_HI);
				if (requests.size() == 0 || idle ||
						(requests[0].hold_off && issued != results_seen)) begin
					start <= 1'b0;
				end else begin
					start <= 1'b1;
					kind <= requests[0].kind;
					value <= requests[0].value;
					position <= requests[0].position;
					requests.delete(0);
				end
			end
		end
	end

	always @(posedge clk) begin
		deq_result_t got;
		deq_result_t want;
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			got = '{data, status, occupancy, front_value, back_value};
			if (expected.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: data %h status %0d occupancy %0d",
						data, status, occupancy);
			end else begin
				want = expected[0];
				expected.delete(0);
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: data %h/%h status %0d/%0d occupancy %0d/%0d ",
							"front %h/%h back %h/%h (expected/actual)"},
							want.data, got.data, want.status, got.status,
							want.occupancy, got.occupancy, want.front_value,
							got.front_value, want.back_value, got.back_value);
				end
			end
		end
	end

	initial begin
		wait (cycle_count == LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		int mode;
		add_request(KIND_QUERY, 32'd0, 7'd0, 1'b0);
		add_request(KIND_POP_FRONT, 32'd0, 7'd0, 1'b0);
		add_request(KIND_POP_BACK, 32'd0, 7'd0, 1'b0);
		add_request(KIND_READ, 32'd0, 7'd0, 1'b0);
		add_request(KIND_READ, 32'd0, 7'd1, 1'b0);
		add_request(KIND_REVERSE, 32'd0, 7'd0, 1'b0);
		add_request(KIND_PUSH_BACK, 32'h7fffffff, 7'd0, 1'b0);
		add_request(KIND_PUSH_FRONT, 32'h80000000, 7'd0, 1'b0);
		add_request(KIND_PUSH_BACK, 32'hffffffff, 7'd0, 1'b0);
		add_request(KIND_PUSH_FRONT, 32'h00000000, 7'd0, 1'b0);
		add_request(KIND_READ, 32'd0, 7'd1, 1'b0);
		add_request(KIND_READ, 32'd0, 7'd4, 1'b0);
		add_request(KIND_READ, 32'd0, 7'd5, 1'b0);
		add_request(KIND_READ, 32'd0, 7'd127, 1'b0);
		add_request(KIND_READ, 32'd0, 7'd0, 1'b0);
		add_request(KIND_REVERSE, 32'd0, 7'd0, 1'b0);
		add_request(KIND_READ, 32'd0, 7'd1, 1'b0);
		add_request(KIND_PUSH_BACK, 32'h12345678, 7'd0, 1'b0);
		add_request(KIND_PUSH_FRONT, 32'h5a5a5a5a, 7'd0, 1'b0);
		add_request(KIND_POP_FRONT, 32'd0, 7'd0, 1'b0);
		add_request(KIND_POP_BACK, 32'd0, 7'd0, 1'b0);
		add_request(KIND_SPARE, 32'hffffffff, 7'h7f, 1'b0);
		add_request(KIND_REVERSE, 32'd0, 7'd0, 1'b0);
		add_request(KIND_POP_FRONT, 32'd0, 7'd0, 1'b0);
		add_request(KIND_POP_BACK, 32'd0, 7'd0, 1'b0);

		for (int seg = 0; seg < 17; seg++) begin
			mode = (seg == 0) ? MODE_FILL : (seg == 1) ? MODE_EMPTY : $urandom_range(0, 2);
			for (int n = 0; n < 100; n++)
				add_random(mode, n == 0 && (seg < 2 || $urandom_range(0, 2) == 0));
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (requests.size() == 0 && !start);
		wait (expected.size() == 0);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
